FILE: src/ppr_pkg.sv
// Shared constants and the arctangent table for the planar point rotator.
// No dependencies; every other file refers to this package by scoped name.
package ppr_pkg;

  // Extra fraction bits carried by the working coordinates.
  localparam int GUARD_BITS = 16;
  // Width of the input binary angle, 65536 counts per turn.
  localparam int ANGLE_BITS = 16;
  // Width of the working angle, 2^32 counts per turn.
  localparam int Z_BITS = 32;
  // Number of entries in the arctangent table.
  localparam int ATAN_LEN = 24;
  // Index width into the arctangent table.
  localparam int ATAN_IDX_BITS = 5;
  // Width of the gain constant as a signed value.
  localparam int GAIN_BITS = 31;
  // CORDIC gain compensation, 1/prod(sqrt(1+2^-2i)) in Q30.
  localparam logic signed [GAIN_BITS-1:0] GAIN_Q30 = 31'sd652032875;
  // Fraction bits of the gain constant.
  localparam int GAIN_FRAC = 30;

  // Quadrant codes, taken from the top two angle bits.
  localparam logic [1:0] QUAD_POS_LOW  = 2'b00;
  localparam logic [1:0] QUAD_POS_HIGH = 2'b01;
  localparam logic [1:0] QUAD_NEG_HIGH = 2'b10;
  localparam logic [1:0] QUAD_NEG_LOW  = 2'b11;

  // atan(2^-i) as a fraction of a full turn, scaled by 2^32.
  function automatic logic signed [Z_BITS-1:0] atan_lut(input logic [ATAN_IDX_BITS-1:0] idx);
    logic signed [Z_BITS-1:0] val;
    case (idx)
      5'd0:    val = 32'sd536870912;
      5'd1:    val = 32'sd316933406;
      5'd2:    val = 32'sd167458907;
      5'd3:    val = 32'sd85004756;
      5'd4:    val = 32'sd42667331;
      5'd5:    val = 32'sd21354465;
      5'd6:    val = 32'sd10679838;
      5'd7:    val = 32'sd5340245;
      5'd8:    val = 32'sd2670163;
      5'd9:    val = 32'sd1335087;
      5'd10:   val = 32'sd667544;
      5'd11:   val = 32'sd333772;
      5'd12:   val = 32'sd166886;
      5'd13:   val = 32'sd83443;
      5'd14:   val = 32'sd41722;
      5'd15:   val = 32'sd20861;
      5'd16:   val = 32'sd10430;
      5'd17:   val = 32'sd5215;
      5'd18:   val = 32'sd2608;
      5'd19:   val = 32'sd1304;
      5'd20:   val = 32'sd652;
      5'd21:   val = 32'sd326;
      5'd22:   val = 32'sd163;
      5'd23:   val = 32'sd81;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

FILE: src/ppr_prerot.sv
// Gain compensation multiply and quadrant pre-rotation, two register stages.
// Depends on ppr_pkg for the gain constant, guard bits and quadrant codes.
module ppr_prerot #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [COORD_WIDTH-1:0]         in_x,
  input  logic signed [COORD_WIDTH-1:0]         in_y,
  input  logic signed [ppr_pkg::ANGLE_BITS-1:0] in_angle,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [COORD_WIDTH+ppr_pkg::GUARD_BITS+1:0] out_x,
  output logic signed [COORD_WIDTH+ppr_pkg::GUARD_BITS+1:0] out_y,
  output logic signed [ppr_pkg::Z_BITS-1:0]     out_z
);

  localparam int W  = COORD_WIDTH + ppr_pkg::GUARD_BITS + 2;
  localparam int PW = COORD_WIDTH + ppr_pkg::GAIN_BITS;
  localparam int SH = ppr_pkg::GAIN_FRAC - ppr_pkg::GUARD_BITS;
  localparam int AB = ppr_pkg::ANGLE_BITS;

  logic                        mul_valid_r;
  logic                        mul_ready;
  logic signed [PW-1:0]        px_r, py_r, px_nxt, py_nxt;
  logic signed [AB-1:0]        ang_r;
  logic                        fold_valid_r;
  logic signed [W-1:0]         x_r, y_r, x_nxt, y_nxt;
  logic signed [ppr_pkg::Z_BITS-1:0] z_r, z_nxt;
  logic signed [PW-1:0]        rx, ry;
  logic signed [W-1:0]         gx, gy;
  logic signed [AB-1:0]        ang_fold;

  // Stage handshakes: a stage takes data when empty or when it is being drained.
  assign mul_ready = !fold_valid_r || out_ready;
  assign in_ready  = !mul_valid_r || mul_ready;

  // Gain compensation products.
  assign px_nxt = PW'(in_x) * PW'(ppr_pkg::GAIN_Q30);
  assign py_nxt = PW'(in_y) * PW'(ppr_pkg::GAIN_Q30);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
    end else if (in_ready) begin
      mul_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      px_r  <= px_nxt;
      py_r  <= py_nxt;
      ang_r <= in_angle;
    end
  end

  // Round half up down to the working scaling, then fold the quadrant.
  always_comb begin
    rx = (px_r + (PW'(1) <<< (SH - 1))) >>> SH;
    ry = (py_r + (PW'(1) <<< (SH - 1))) >>> SH;
    gx = W'(rx);
    gy = W'(ry);
    case (ang_r[AB-1:AB-2])
      ppr_pkg::QUAD_POS_HIGH: begin
        x_nxt    = -gy;
        y_nxt    = gx;
        ang_fold = ang_r - (AB'(1) <<< (AB - 2));
      end
      ppr_pkg::QUAD_NEG_HIGH: begin
        x_nxt    = gy;
        y_nxt    = -gx;
        ang_fold = ang_r + (AB'(1) <<< (AB - 2));
      end
      default: begin
        x_nxt    = gx;
        y_nxt    = gy;
        ang_fold = ang_r;
      end
    endcase
    z_nxt = {ang_fold, {(ppr_pkg::Z_BITS - AB){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_valid_r <= 1'b0;
    end else if (mul_ready) begin
      fold_valid_r <= mul_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_valid_r && mul_ready) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign out_valid = fold_valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_z     = z_r;

  // An accepted transfer always lands in the multiply stage on the next edge.
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> mul_valid_r)
    else $error("accepted transfer did not reach the multiply stage");

endmodule

FILE: src/ppr_cordic_stage.sv
// One CORDIC micro-rotation in rotation mode, with its own pipeline register.
// Depends on ppr_pkg for the arctangent table and the working widths.
module ppr_cordic_stage #(
  parameter int COORD_WIDTH = 16,
  parameter int STEP_IDX    = 0
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [COORD_WIDTH+ppr_pkg::GUARD_BITS+1:0] in_x,
  input  logic signed [COORD_WIDTH+ppr_pkg::GUARD_BITS+1:0] in_y,
  input  logic signed [ppr_pkg::Z_BITS-1:0]     in_z,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [COORD_WIDTH+ppr_pkg::GUARD_BITS+1:0] out_x,
  output logic signed [COORD_WIDTH+ppr_pkg::GUARD_BITS+1:0] out_y,
  output logic signed [ppr_pkg::Z_BITS-1:0]     out_z
);

  localparam int W = COORD_WIDTH + ppr_pkg::GUARD_BITS + 2;
  localparam logic signed [ppr_pkg::Z_BITS-1:0] ATAN =
    ppr_pkg::atan_lut(ppr_pkg::ATAN_IDX_BITS'(STEP_IDX));

  logic                              valid_r;
  logic signed [W-1:0]               x_r, y_r, x_nxt, y_nxt;
  logic signed [ppr_pkg::Z_BITS-1:0] z_r, z_nxt;
  logic signed [W-1:0]               dx, dy;

  assign in_ready = !valid_r || out_ready;

  // Turn towards zero residual angle; the shifts round toward minus infinity.
  always_comb begin
    dx = in_y >>> STEP_IDX;
    dy = in_x >>> STEP_IDX;
    if (!in_z[ppr_pkg::Z_BITS-1]) begin
      x_nxt = in_x - dx;
      y_nxt = in_y + dy;
      z_nxt = in_z - ATAN;
    end else begin
      x_nxt = in_x + dx;
      y_nxt = in_y - dy;
      z_nxt = in_z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_z     = z_r;

endmodule

FILE: src/ppr_round.sv
// Output stage: rounds the working coordinates back to the input scaling.
// Depends on ppr_pkg for the guard bit count.
module ppr_round #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [COORD_WIDTH+ppr_pkg::GUARD_BITS+1:0] in_x,
  input  logic signed [COORD_WIDTH+ppr_pkg::GUARD_BITS+1:0] in_y,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [COORD_WIDTH:0]           out_x,
  output logic signed [COORD_WIDTH:0]           out_y
);

  localparam int W = COORD_WIDTH + ppr_pkg::GUARD_BITS + 2;
  localparam int G = ppr_pkg::GUARD_BITS;

  logic                     valid_r;
  logic signed [COORD_WIDTH:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [W-1:0]      sx, sy;

  assign in_ready = !valid_r || out_ready;

  // Round half up and drop the guard bits.
  always_comb begin
    sx    = (in_x + (W'(1) <<< (G - 1))) >>> G;
    sy    = (in_y + (W'(1) <<< (G - 1))) >>> G;
    x_nxt = sx[COORD_WIDTH:0];
    y_nxt = sy[COORD_WIDTH:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;

endmodule

FILE: src/planar_point_rotator.sv
// Planar point rotator: rotates (x, y) counterclockwise by a binary angle.
// Depends on ppr_pkg, ppr_prerot, ppr_cordic_stage and ppr_round.
//
// Usage:
//   Input channel in_valid/in_ready carries in_point_x, in_point_y (signed
//   Q8.8 at COORD_WIDTH bits) and in_turn_angle (signed, 65536 counts per
//   turn). A transfer happens when valid and ready are both high.
//   Result channel out_valid/out_ready carries out_rotated_x and
//   out_rotated_y, signed at COORD_WIDTH+1 bits, one result per point, in order.
//   A point passes through the gain multiply and quadrant fold registers,
//   then one register per micro-rotation stage, and last the output
//   rounding register.
//   Throughput is one point per cycle while out_ready stays high; every stage
//   holds one point and passes it on as soon as the next stage is free.
//   Reset clears all stage valid bits; the pipeline is empty and ready in the
//   first cycle after reset. No clearing pass is needed.
//   When the receiver stalls, the result holds on the outputs, stages fill up
//   behind it and in_ready falls only once every stage is occupied, so bubbles
//   are squeezed out and nothing is lost or repeated.
module planar_point_rotator #(
  parameter int CORDIC_STEPS = 16,
  parameter int COORD_WIDTH  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [COORD_WIDTH-1:0]         in_point_x,
  input  logic signed [COORD_WIDTH-1:0]         in_point_y,
  input  logic signed [ppr_pkg::ANGLE_BITS-1:0] in_turn_angle,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [COORD_WIDTH:0]           out_rotated_x,
  output logic signed [COORD_WIDTH:0]           out_rotated_y
);

  localparam int W = COORD_WIDTH + ppr_pkg::GUARD_BITS + 2;

  // Chain signals: index 0 is the pre-rotation output, index k the output of step k-1.
  logic                              chain_valid [CORDIC_STEPS+1];
  logic                              chain_ready [CORDIC_STEPS+1];
  logic signed [W-1:0]               chain_x     [CORDIC_STEPS+1];
  logic signed [W-1:0]               chain_y     [CORDIC_STEPS+1];
  logic signed [ppr_pkg::Z_BITS-1:0] chain_z     [CORDIC_STEPS+1];

  // Gain compensation and quadrant fold.
  ppr_prerot #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_prerot (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_x      (in_point_x),
    .in_y      (in_point_y),
    .in_angle  (in_turn_angle),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0]),
    .out_x     (chain_x[0]),
    .out_y     (chain_y[0]),
    .out_z     (chain_z[0])
  );

  // Micro-rotation stages, one register stage each.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    ppr_cordic_stage #(
      .COORD_WIDTH (COORD_WIDTH),
      .STEP_IDX    (i)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_valid[i]),
      .in_ready  (chain_ready[i]),
      .in_x      (chain_x[i]),
      .in_y      (chain_y[i]),
      .in_z      (chain_z[i]),
      .out_valid (chain_valid[i+1]),
      .out_ready (chain_ready[i+1]),
      .out_x     (chain_x[i+1]),
      .out_y     (chain_y[i+1]),
      .out_z     (chain_z[i+1])
    );
  end

  // Output rounding register; the residual angle is no longer needed.
  ppr_round #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (chain_valid[CORDIC_STEPS]),
    .in_ready  (chain_ready[CORDIC_STEPS]),
    .in_x      (chain_x[CORDIC_STEPS]),
    .in_y      (chain_y[CORDIC_STEPS]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_x     (out_rotated_x),
    .out_y     (out_rotated_y)
  );

  // With the output register empty, the ready chain must reach the input.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled although the output register is empty");

  // The rotated magnitude stays below 2^COORD_WIDTH, so the most negative code never appears.
  a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rotated_x != {1'b1, {COORD_WIDTH{1'b0}}})
    else $error("rotated x outside the magnitude bound");

  a_y_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rotated_y != {1'b1, {COORD_WIDTH{1'b0}}})
    else $error("rotated y outside the magnitude bound");

endmodule
